>>> hw/rtl/phtm_pkg.sv
// shared types and constants of the per-host traffic meter
package phtm_pkg;

  localparam int unsigned PhtmEntries    = 256;
  localparam int unsigned PhtmAppClasses = 16;
  localparam int unsigned ClassBitsW     = 15;
  localparam logic [15:0] TicksReset     = 16'd100;

  typedef struct packed {
    logic [7:0]  entry_index;
    logic        from_lan;
    logic [15:0] length;
    logic [31:0] now;
    logic [7:0]  app_class;
    logic [47:0] source_mac;
    logic        mac_valid;
  } in_item_t;

  typedef struct packed {
    logic [63:0]           tx_total;
    logic [63:0]           rx_total;
    logic [31:0]           rate_tx;
    logic [31:0]           rate_rx;
    logic [ClassBitsW-1:0] class_seen;
    logic                  first_receive;
  } result_t;

  typedef struct packed {
    logic [63:0]           send_total;
    logic [63:0]           recv_total;
    logic [31:0]           send_sum;
    logic [31:0]           recv_sum;
    logic [31:0]           send_rate;
    logic [31:0]           recv_rate;
    logic [31:0]           win_start;
    logic [ClassBitsW-1:0] class_bits;
    logic [47:0]           host_mac;
  } rec_t;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> hw/rtl/phtm_ram.sv
// generic simple dual-port ram with registered read
module phtm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/per_host_traffic_meter.sv
// per-host packet accounting table: top level
//
// Usage:
//   An input transaction is taken at a rising edge with start high and busy low.
//   item_i carries the host index, direction, length, tick, class and MAC.
//   Every transaction gives exactly one result: result_valid_o is high for one
//   cycle with result_o; the accepted input is registered into stage s1, where
//   the table read returns, and the result is registered from s1. The receiver
//   cannot stall; results are never held.
//   Throughput is one transaction per cycle while busy is low: the host table is
//   one memory, read on the accepting edge and written back in the next cycle; a
//   back-to-back hit on the same host takes the written record from a
//   forwarding register.
//   ticks_per_second is written over the cfg channel (always ready).
//   After reset busy is high while a clearing pass zeros the table one entry a
//   cycle; ticks_per_second resets to 100.
//   An index beyond the table gives an all-zero result and changes nothing.
module per_host_traffic_meter
  import phtm_pkg::*;
#(
  parameter int unsigned ENTRIES     = PhtmEntries,
  parameter int unsigned APP_CLASSES = PhtmAppClasses
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item_i,
  output logic        result_valid_o,
  output result_t     result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW   = $clog2(ENTRIES);
  localparam int unsigned IdxW = (AW > 8) ? AW : 8;
  localparam int unsigned RecW = $bits(rec_t);

  logic [15:0]   ticks_q;
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  logic          s1_valid_q;
  logic          s1_ok_q;
  logic [AW-1:0] s1_addr_q;
  in_item_t      s1_item_q;

  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  rec_t          fwd_rec_q;

  logic          result_valid_q;
  result_t       result_q;
  result_t       result_d;

  logic          accept;
  logic [IdxW-1:0] idx_ext;
  logic [AW-1:0] rd_addr;
  logic          idx_ok;
  logic [RecW-1:0] ram_rdata;
  rec_t          rec;
  rec_t          nrec;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  rec_t          ram_wdata;

  logic [31:0]   t1;
  logic [31:0]   t2;
  logic [31:0]   d1;
  logic [31:0]   d2;
  logic          closed;
  logic          gap;
  logic [31:0]   len32;
  logic [ClassBitsW-1:0] cls_mask;
  logic          first;

  assign accept      = start && !busy;
  assign busy        = clr_q;
  assign cfg_ready_o = 1'b1;
  assign idx_ext     = IdxW'(item_i.entry_index);
  assign rd_addr     = idx_ext[AW-1:0];
  assign idx_ok      = ({24'd0, item_i.entry_index} < 32'(ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ticks_q <= cfg_data_i;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AW'(ENTRIES - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  phtm_ram #(
    .WIDTH(RecW),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_i;
      s1_ok_q   <= idx_ok;
      s1_addr_q <= rd_addr;
    end
  end

  // forward the record written last cycle
  assign rec = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_rec_q : rec_t'(ram_rdata);

  always_comb begin
    nrec     = rec;
    len32    = {16'd0, s1_item_q.length};
    t1       = rec.win_start + {16'd0, ticks_q};
    t2       = rec.win_start + {15'd0, ticks_q, 1'b0};
    d1       = t1 - s1_item_q.now;
    d2       = t2 - s1_item_q.now;
    closed   = d1[31];
    gap      = d2[31];
    first    = 1'b0;
    for (int j = 0; j < ClassBitsW; j++) begin
      cls_mask[j] = (s1_item_q.app_class == 8'(j + 1)) && ((j + 1) < APP_CLASSES);
    end
    if (s1_item_q.from_lan) begin
      nrec.host_mac   = s1_item_q.mac_valid ? s1_item_q.source_mac : '0;
      nrec.send_total = rec.send_total + 64'(s1_item_q.length);
      nrec.class_bits = rec.class_bits | cls_mask;
      if (closed) begin
        nrec.send_rate = gap ? '0 : rec.send_sum;
        nrec.send_sum  = len32;
        nrec.recv_sum  = '0;
        nrec.win_start = s1_item_q.now;
      end else begin
        nrec.send_sum = sat_add32(rec.send_sum, len32);
      end
    end else begin
      nrec.recv_total = rec.recv_total + 64'(s1_item_q.length);
      first = (rec.recv_total == '0) && (nrec.recv_total != '0);
      if (closed) begin
        nrec.recv_rate = gap ? '0 : rec.recv_sum;
        nrec.recv_sum  = len32;
        nrec.send_sum  = '0;
        nrec.win_start = s1_item_q.now;
      end else begin
        nrec.recv_sum = sat_add32(rec.recv_sum, len32);
      end
    end
    if (s1_ok_q) begin
      result_d.tx_total      = nrec.send_total;
      result_d.rx_total      = nrec.recv_total;
      result_d.rate_tx       = nrec.send_rate;
      result_d.rate_rx       = nrec.recv_rate;
      result_d.class_seen    = nrec.class_bits;
      result_d.first_receive = first;
    end else begin
      result_d = '0;
    end
  end

  assign ram_we    = clr_q || (s1_valid_q && s1_ok_q);
  assign ram_waddr = clr_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_q ? rec_t'('0) : nrec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q    <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      fwd_valid_q    <= s1_valid_q && s1_ok_q;
      result_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s1_addr_q;
    fwd_rec_q  <= nrec;
    if (s1_valid_q) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // no transaction in flight during the clearing pass
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_valid_q && !result_valid_q)
    else $error("transaction in flight while clearing");

  // every accepted transaction yields a result, registered after stage s1
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 result_valid_o)
    else $error("result missing");

  // out-of-range index leaves the table alone and reports zeros
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_ok_q |=> result_q == '0)
    else $error("out-of-range result not zero");

  // table writes only from the clearing pass or a valid update
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && !clr_q |-> s1_valid_q && s1_ok_q)
    else $error("stray table write");

endmodule

>>> dv/tb_per_host_traffic_meter.sv
// testbench for the per-host traffic meter: random and directed packets checked against a predictor
`timescale 1ns / 100ps

module tb_per_host_traffic_meter;
  import phtm_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  in_item_t    item_i      = '0;
  logic        result_valid_o;
  result_t     result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;

  per_host_traffic_meter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor copy of the host table
  logic [63:0]           send_total [PhtmEntries];
  logic [63:0]           recv_total [PhtmEntries];
  logic [31:0]           send_sum   [PhtmEntries];
  logic [31:0]           recv_sum   [PhtmEntries];
  logic [31:0]           send_rate  [PhtmEntries];
  logic [31:0]           recv_rate  [PhtmEntries];
  logic [31:0]           win_start  [PhtmEntries];
  logic [ClassBitsW-1:0] class_bits [PhtmEntries];
  logic [47:0]           host_mac   [PhtmEntries];
  logic [15:0]           ticks_cfg  = TicksReset;

  in_item_t packet_queue[$];
  result_t  predicted_readings[$];

  int unsigned errors     = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_closed   = 0;
  int unsigned n_gap      = 0;
  int unsigned n_first    = 0;
  int unsigned n_settings = 1;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  initial begin
    for (int i = 0; i < PhtmEntries; i++) begin
      send_total[i] = '0;
      recv_total[i] = '0;
      send_sum[i]   = '0;
      recv_sum[i]   = '0;
      send_rate[i]  = '0;
      recv_rate[i]  = '0;
      win_start[i]  = '0;
      class_bits[i] = '0;
      host_mac[i]   = '0;
    end
  end

  function automatic logic [31:0] sum_sat(logic [31:0] a, logic [15:0] len);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, len};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic result_t account_packet(in_item_t p);
    result_t     r;
    logic [31:0] d1;
    logic [31:0] d2;
    logic        closed;
    logic        gap;
    logic [63:0] old_rx;
    logic        first;
    int unsigned i;
    r     = '0;
    first = 1'b0;
    if (p.entry_index >= PhtmEntries) return r;
    i      = 32'(p.entry_index);
    d1     = win_start[i] + {16'd0, ticks_cfg} - p.now;
    d2     = win_start[i] + ({16'd0, ticks_cfg} << 1) - p.now;
    closed = d1[31];
    gap    = d2[31];
    if (closed) n_closed++;
    if (closed && gap) n_gap++;
    if (p.from_lan) begin
      host_mac[i]   = p.mac_valid ? p.source_mac : 48'd0;
      send_total[i] = send_total[i] + {48'd0, p.length};
      if (p.app_class > 0 && p.app_class < PhtmAppClasses && p.app_class <= ClassBitsW) begin
        class_bits[i] = class_bits[i] | (ClassBitsW'(1) << (p.app_class - 1));
      end
      if (closed) begin
        send_rate[i] = gap ? 32'd0 : send_sum[i];
        send_sum[i]  = {16'd0, p.length};
        recv_sum[i]  = '0;
        win_start[i] = p.now;
      end else begin
        send_sum[i] = sum_sat(send_sum[i], p.length);
      end
    end else begin
      old_rx        = recv_total[i];
      recv_total[i] = old_rx + {48'd0, p.length};
      first         = (old_rx == 64'd0) && (recv_total[i] != 64'd0);
      if (closed) begin
        recv_rate[i] = gap ? 32'd0 : recv_sum[i];
        recv_sum[i]  = {16'd0, p.length};
        send_sum[i]  = '0;
        win_start[i] = p.now;
      end else begin
        recv_sum[i] = sum_sat(recv_sum[i], p.length);
      end
    end
    if (first) n_first++;
    r.tx_total      = send_total[i];
    r.rx_total      = recv_total[i];
    r.rate_tx       = send_rate[i];
    r.rate_rx       = recv_rate[i];
    r.class_seen    = class_bits[i];
    r.first_receive = first;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (errors < 50) begin
      $display("mismatch %s at %0t: got %0h want %0h", field, $realtime, got, want);
    end
    errors++;
  endtask

  // driver: bursts of packets with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start  <= 1'b0;
      item_i <= '0;
    end else begin
      if (start && !busy) begin
        predicted_readings.push_back(account_packet(item_i));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (packet_queue.size() != 0) begin
          item_i <= packet_queue.pop_front();
          start  <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (predicted_readings.size() == 0) begin
        report_mismatch("result with no prediction, tx_total", result_o.tx_total, 64'd0);
      end else begin
        result_t want;
        want = predicted_readings.pop_front();
        n_checked++;
        if (result_o.tx_total !== want.tx_total)
          report_mismatch("tx_total", result_o.tx_total, want.tx_total);
        if (result_o.rx_total !== want.rx_total)
          report_mismatch("rx_total", result_o.rx_total, want.rx_total);
        if (result_o.rate_tx !== want.rate_tx)
          report_mismatch("rate_tx", 64'(result_o.rate_tx), 64'(want.rate_tx));
        if (result_o.rate_rx !== want.rate_rx)
          report_mismatch("rate_rx", 64'(result_o.rate_rx), 64'(want.rate_rx));
        if (result_o.class_seen !== want.class_seen)
          report_mismatch("class_seen", 64'(result_o.class_seen), 64'(want.class_seen));
        if (result_o.first_receive !== want.first_receive)
          report_mismatch("first_receive", 64'(result_o.first_receive),
                          64'(want.first_receive));
      end
    end
  end

  function automatic in_item_t mk_pkt(logic [7:0] idx, logic up, logic [15:0] len,
                                      logic [31:0] now, logic [7:0] cls,
                                      logic [47:0] mac, logic ok);
    in_item_t p;
    p.entry_index = idx;
    p.from_lan    = up;
    p.length      = len;
    p.now         = now;
    p.app_class   = cls;
    p.source_mac  = mac;
    p.mac_valid   = ok;
    return p;
  endfunction

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (packet_queue.size() != 0 || start || predicted_readings.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_ticks(logic [15:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ticks_cfg = value;
    n_settings++;
  endtask

  task automatic queue_random(int unsigned count, logic wrap_start);
    int unsigned span;
    int unsigned r;
    int unsigned hot[4];
    logic [31:0] tick;
    logic [31:0] stamp;
    logic [7:0]  idx;
    logic [15:0] len;
    logic [7:0]  cls;
    span = (ticks_cfg == 0) ? 4 : 32'(ticks_cfg);
    foreach (hot[k]) hot[k] = $urandom_range(0, 255);
    tick = wrap_start ? (32'd0 - span * $urandom_range(0, 60)) : $urandom;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) tick = tick + $urandom_range(0, span / 8 + 1);
      else if (r < 85) tick = tick + $urandom_range(span, 3 * span);
      else if (r < 92) tick = tick;
      else if (r < 96) tick = tick - $urandom_range(0, span);
      stamp = (r >= 96) ? $urandom : tick;
      idx = ($urandom_range(0, 9) < 7) ? 8'(hot[$urandom_range(0, 3)])
                                       : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 9);
      len = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 19);
      cls = (r < 12) ? 8'($urandom_range(1, 15)) : (r < 15) ? 8'd0
                                                 : 8'($urandom_range(0, 255));
      packet_queue.push_back(mk_pkt(idx, 1'($urandom_range(0, 1)), len, stamp, cls,
                                    48'({$urandom, $urandom}),
                                    $urandom_range(0, 4) != 0));
    end
  endtask

  initial begin
    logic [15:0] settings[6];
    settings = '{16'd1, 16'd65535, 16'd0, 16'd0, 16'd7, 16'd1000};
    settings[3] = 16'($urandom_range(2, 65534));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default window length from reset
    packet_queue.push_back(mk_pkt(8'd0, 1'b1, 16'hFFFF, 32'd0,   8'd1,   48'hFFFF_FFFF_FFFF, 1'b1));
    packet_queue.push_back(mk_pkt(8'd0, 1'b1, 16'd1,    32'd50,  8'd15,  48'h0123_4567_89AB, 1'b0));
    packet_queue.push_back(mk_pkt(8'd0, 1'b1, 16'd2,    32'd60,  8'd0,   48'h0000_0000_0001, 1'b1));
    packet_queue.push_back(mk_pkt(8'd0, 1'b1, 16'd3,    32'd70,  8'd16,  48'h8000_0000_0000, 1'b1));
    packet_queue.push_back(mk_pkt(8'd0, 1'b1, 16'd4,    32'd100, 8'd255, 48'h0,              1'b1));
    packet_queue.push_back(mk_pkt(8'd0, 1'b1, 16'd5,    32'd101, 8'd14,  48'h5555_AAAA_5555, 1'b1));
    packet_queue.push_back(mk_pkt(8'd0, 1'b0, 16'd0,    32'd150, 8'd3,   48'h0,              1'b1));
    packet_queue.push_back(mk_pkt(8'd0, 1'b0, 16'd9,    32'd160, 8'd3,   48'h0,              1'b1));
    packet_queue.push_back(mk_pkt(8'd0, 1'b1, 16'd6,    32'd500, 8'd2,   48'hAAAA_5555_AAAA, 1'b1));
    packet_queue.push_back(mk_pkt(8'd0, 1'b0, 16'hFFFF, 32'd601, 8'd0,   48'h0,              1'b0));
    packet_queue.push_back(mk_pkt(8'd0, 1'b0, 16'd7,    32'd650, 8'd0,   48'h0,              1'b0));
    packet_queue.push_back(mk_pkt(8'd0, 1'b0, 16'd8,    32'd702, 8'd0,   48'h0,              1'b0));
    packet_queue.push_back(mk_pkt(8'd255, 1'b0, 16'hFFFF, 32'hFFFF_FFF0, 8'd5, 48'h1, 1'b1));
    packet_queue.push_back(mk_pkt(8'd255, 1'b0, 16'd1,    32'h0000_0010, 8'd5, 48'h1, 1'b1));
    packet_queue.push_back(mk_pkt(8'd255, 1'b1, 16'd1,    32'h0000_0065, 8'd5, 48'h1, 1'b1));
    packet_queue.push_back(mk_pkt(8'd1,   1'b1, 16'd10,   32'h8000_0000, 8'd8, 48'h2, 1'b1));
    packet_queue.push_back(mk_pkt(8'd1,   1'b1, 16'd10,   32'h8000_0063, 8'd8, 48'h2, 1'b1));
    packet_queue.push_back(mk_pkt(8'd2,   1'b1, 16'd11,   32'h7FFF_FFFF, 8'd9, 48'h3, 1'b1));
    packet_queue.push_back(mk_pkt(8'd2,   1'b0, 16'd12,   32'h8000_0000, 8'd9, 48'h3, 1'b1));
    queue_random(236, 1'b0);
    wait_quiet();

    foreach (settings[s]) begin
      write_ticks(settings[s]);
      queue_random(236, s[0]);
      wait_quiet();
    end

    repeat (10) @(negedge clk_i);
    if (predicted_readings.size() != 0)
      report_mismatch("results never arrived", 64'(predicted_readings.size()), 64'd0);
    $display("covered %0d packets under %0d window settings, %0d results checked",
             n_accepted, n_settings, n_checked);
    $display("window closes %0d (%0d after long gaps), first receives %0d",
             n_closed, n_gap, n_first);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", predicted_readings.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/phtm_pkg.sv
hw/rtl/phtm_ram.sv
hw/rtl/per_host_traffic_meter.sv
dv/tb_per_host_traffic_meter.sv
